### rtl/pwbs_pkg.sv
`default_nettype none

package pwbs_pkg;

    localparam int DATA_BITS = 8;
    localparam int BYTE_W    = 8;
    localparam int TICK_W    = 8;
    localparam int BIT_IDX_W = $clog2(DATA_BITS + 1);
    localparam int IDX_EXT_W = (BIT_IDX_W > 4) ? BIT_IDX_W : 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS  = 1'b1;

    localparam logic [TICK_W-1:0] HEAD_TICKS_RST = 8'd25;
    localparam logic [TICK_W-1:0] BIT_TICKS_RST  = 8'd2;

    typedef enum logic [4:0] {
        PH_HEAD = 5'b00001,
        PH_SURE = 5'b00010,
        PH_ONE  = 5'b00100,
        PH_ZERO = 5'b01000,
        PH_END  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } t_out_res;

    typedef struct packed {
        logic [TICK_W-1:0] head_ticks;
        logic [TICK_W-1:0] bit_ticks;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/pulse_width_byte_sender_core.sv
// channel   | valid   | stall   | payload
// ----------+---------+---------+-----------------------------------
// request   | i_valid | o_stall | i_req  (func, data_byte)
// result    | o_valid | i_stall | o_res  (line_level, busy_res, frame_done)
// config    | i_cfg_we| -       | i_cfg_idx, i_cfg_wdata
//
// One request per clock while i_stall is low; path: input register, then result register.
// Each request makes exactly one result; state updates when the request enters the result register.
// i_rst_n is synchronous, active low; line idles high, config returns to 25 / 2.
// A stalled result holds; o_stall rises only while the input register is full and cannot drain.
`default_nettype none

module pulse_width_byte_sender_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire pwbs_pkg::t_in_req                  i_req,
    output logic                                    o_stall,
    output logic                                    o_valid,
    output pwbs_pkg::t_out_res                      o_res,
    input  wire logic                               i_stall,
    input  wire logic                               i_cfg_we,
    input  wire logic [pwbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pwbs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import pwbs_pkg::*;

    t_cfg      r_cfg;
    logic      r_s1_valid, n_s1_valid;
    t_in_req   r_s1_req;
    logic      r_o_valid,  n_o_valid;
    t_out_res  r_res;
    t_out_res  step_res;
    logic      out_free;
    logic      s1_move;
    logic      in_take;

    assign out_free = !r_o_valid || !i_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    assign n_s1_valid = in_take ? 1'b1 : (out_free ? 1'b0 : r_s1_valid);
    assign n_o_valid  = out_free ? r_s1_valid : 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_ticks <= HEAD_TICKS_RST;
            r_cfg.bit_ticks  <= BIT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEAD_TICKS: r_cfg.head_ticks <= TICK_W'(i_cfg_wdata);
                CFG_BIT_TICKS:  r_cfg.bit_ticks  <= TICK_W'(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_req <= i_req;
        end
        if (s1_move) begin
            r_res <= step_res;
        end
    end

    pwbs_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_move),
        .i_req   (r_s1_req),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    assign o_valid = r_o_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.frame_done |-> o_res.line_level && !o_res.busy_res)
        else $error("done result not idle high");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_s1_req.func |=> o_valid && o_res.busy_res && !o_res.frame_done)
        else $error("start request did not report busy");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_o_valid && i_stall)
        else $error("stall without full stages");
`endif

endmodule

`default_nettype wire

### rtl/pwbs_engine.sv
`default_nettype none

module pwbs_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire pwbs_pkg::t_in_req i_req,
    input  wire pwbs_pkg::t_cfg    i_cfg,
    output pwbs_pkg::t_out_res     o_res
);
    import pwbs_pkg::*;

    t_phase                 r_phase,      n_phase;
    logic [TICK_W-1:0]      r_tick_count, n_tick_count;
    logic [BIT_IDX_W-1:0]   r_bit_index,  n_bit_index;
    logic [BYTE_W-1:0]      r_frame_byte, n_frame_byte;
    logic                   r_wire_level, n_wire_level;
    logic                   done;
    logic [IDX_EXT_W-1:0]   idx_ext;
    logic                   cur_bit;
    logic [TICK_W-1:0]      tick_inc;
    logic [BIT_IDX_W-1:0]   bit_inc;

    assign idx_ext  = IDX_EXT_W'(r_bit_index);
    assign cur_bit  = (idx_ext < IDX_EXT_W'(BYTE_W)) ? r_frame_byte[idx_ext[2:0]] : 1'b0;
    assign tick_inc = r_tick_count + TICK_W'(1);
    assign bit_inc  = r_bit_index + BIT_IDX_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_bit_index  = r_bit_index;
        n_frame_byte = r_frame_byte;
        n_wire_level = r_wire_level;
        done         = 1'b0;
        if (i_req.func) begin
            n_phase      = PH_HEAD;
            n_tick_count = '0;
            n_bit_index  = '0;
            n_frame_byte = i_req.data_byte;
        end else begin
            case (r_phase)
                PH_HEAD: begin
                    n_wire_level = 1'b0;
                    if (r_tick_count >= i_cfg.head_ticks) begin
                        n_tick_count = TICK_W'(1);
                        n_bit_index  = '0;
                        n_phase      = PH_SURE;
                    end else begin
                        n_tick_count = tick_inc;
                    end
                end
                PH_SURE: begin
                    n_tick_count = '0;
                    n_wire_level = 1'b1;
                    if (r_bit_index >= BIT_IDX_W'(DATA_BITS)) begin
                        n_bit_index = '0;
                        n_phase     = PH_END;
                        done        = 1'b1;
                    end else begin
                        n_phase = cur_bit ? PH_ONE : PH_ZERO;
                    end
                end
                PH_ONE: begin
                    if (r_tick_count >= i_cfg.bit_ticks) begin
                        n_wire_level = 1'b0;
                        n_phase      = PH_SURE;
                        n_tick_count = TICK_W'(1);
                        n_bit_index  = bit_inc;
                    end else begin
                        n_wire_level = 1'b1;
                        n_tick_count = tick_inc;
                    end
                end
                PH_ZERO: begin
                    if (r_tick_count >= i_cfg.bit_ticks) begin
                        n_phase      = PH_SURE;
                        n_tick_count = TICK_W'(1);
                        n_bit_index  = bit_inc;
                    end else begin
                        n_wire_level = 1'b0;
                        n_tick_count = tick_inc;
                    end
                end
                default: begin
                    n_phase = PH_END;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_END;
            r_tick_count <= '0;
            r_bit_index  <= '0;
            r_frame_byte <= '0;
            r_wire_level <= 1'b1;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_frame_byte <= n_frame_byte;
            r_wire_level <= n_wire_level;
        end
    end

    assign o_res.line_level = n_wire_level;
    assign o_res.busy_res   = (n_phase != PH_END);
    assign o_res.frame_done = done;

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= BIT_IDX_W'(DATA_BITS))
        else $error("bit index past frame length");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && done |=> r_phase == PH_END && r_wire_level)
        else $error("frame end did not idle high");
    a_head_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !i_req.func && r_phase == PH_HEAD |=> !r_wire_level)
        else $error("line not low in head");
`endif

endmodule

`default_nettype wire

### sim/pulse_width_byte_sender_core_tb.sv
`timescale 1ns / 100ps

module pulse_width_byte_sender_core_tb;
    import pwbs_pkg::*;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;

    // Tracks the expected wire level, busy and done flags per accepted request.
    class frame_line_scoreboard;
        t_phase            phase;
        logic [TICK_W-1:0] tick_cnt;
        logic [TICK_W-1:0] head_ticks;
        logic [TICK_W-1:0] pulse_ticks;
        logic [BYTE_W-1:0] frame_byte;
        logic [3:0]        bit_idx;
        logic              wire_lvl;
        t_out_res          line_results_q[$];
        int                fail_count;

        function new();
            phase       = PH_END;
            tick_cnt    = '0;
            head_ticks  = HEAD_TICKS_RST;
            pulse_ticks = BIT_TICKS_RST;
            frame_byte  = '0;
            bit_idx     = '0;
            wire_lvl    = 1'b1;
            fail_count  = 0;
        endfunction

        function void set_ticks(logic [TICK_W-1:0] head, logic [TICK_W-1:0] pulse);
            head_ticks  = head;
            pulse_ticks = pulse;
        endfunction

        function bit frame_busy();
            return phase != PH_END;
        endfunction

        function int pending();
            return line_results_q.size();
        endfunction

        function void note_request(t_in_req r);
            t_out_res res;
            logic     done;
            logic     cur_bit;
            done = 1'b0;
            if (r.func == FUNC_START) begin
                phase      = PH_HEAD;
                tick_cnt   = '0;
                bit_idx    = '0;
                frame_byte = r.data_byte;
            end else begin
                case (phase)
                    PH_HEAD: begin
                        wire_lvl = 1'b0;
                        if (tick_cnt >= head_ticks) begin
                            tick_cnt = '0;
                            bit_idx  = '0;
                            phase    = PH_SURE;
                        end
                        tick_cnt = tick_cnt + 1'b1;
                    end
                    PH_SURE: begin
                        if (bit_idx >= DATA_BITS) begin
                            tick_cnt = '0;
                            bit_idx  = '0;
                            wire_lvl = 1'b1;
                            phase    = PH_END;
                            done     = 1'b1;
                        end else begin
                            cur_bit  = (bit_idx < BYTE_W) ? frame_byte[bit_idx[2:0]] : 1'b0;
                            phase    = cur_bit ? PH_ONE : PH_ZERO;
                            tick_cnt = '0;
                            wire_lvl = 1'b1;
                        end
                    end
                    PH_ONE: begin
                        if (tick_cnt >= pulse_ticks) begin
                            wire_lvl = 1'b0;
                            phase    = PH_SURE;
                            tick_cnt = '0;
                            bit_idx  = bit_idx + 1'b1;
                        end else begin
                            wire_lvl = 1'b1;
                        end
                        tick_cnt = tick_cnt + 1'b1;
                    end
                    PH_ZERO: begin
                        if (tick_cnt >= pulse_ticks) begin
                            phase    = PH_SURE;
                            tick_cnt = '0;
                            bit_idx  = bit_idx + 1'b1;
                        end else begin
                            wire_lvl = 1'b0;
                        end
                        tick_cnt = tick_cnt + 1'b1;
                    end
                    PH_END: ;
                    default: phase = PH_END;
                endcase
            end
            res.line_level = wire_lvl;
            res.busy_res   = (phase != PH_END);
            res.frame_done = done;
            line_results_q.push_back(res);
        endfunction

        function void check_result(t_out_res got);
            t_out_res exp_res;
            if (line_results_q.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result line=%b busy=%b done=%b",
                             got.line_level, got.busy_res, got.frame_done);
                fail_count++;
                return;
            end
            exp_res = line_results_q.pop_front();
            if (got !== exp_res) begin
                if (fail_count < 10)
                    $display("mismatch: expected line=%b busy=%b done=%b, got line=%b busy=%b done=%b",
                             exp_res.line_level, exp_res.busy_res, exp_res.frame_done,
                             got.line_level, got.busy_res, got.frame_done);
                fail_count++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    t_in_req               i_req;
    logic                  o_stall;
    logic                  o_valid;
    t_out_res              o_res;
    logic                  i_stall;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    frame_line_scoreboard sb = new();
    bit idle_en = 1'b1;
    int stall_left = 0;
    int cycle_cnt = 0;

    pulse_width_byte_sender_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req      (i_req),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("pulse_width_byte_sender_core_tb failed");
            $finish;
        end
    end

    // result-side backpressure in random-length bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_en) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_res);
    end

    task automatic send_req(input logic func, input logic [BYTE_W-1:0] data);
        t_in_req r;
        r.func      = func;
        r.data_byte = data;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(r);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_tick_regs(input logic [TICK_W-1:0] head,
                                   input logic [TICK_W-1:0] pulse);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_HEAD_TICKS;
        i_cfg_wdata <= head;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_BIT_TICKS;
        i_cfg_wdata <= pulse;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_ticks(head, pulse);
    endtask

    // well-formed frames with random bytes, occasional restarts and idle ticks
    task automatic send_frames(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            send_req(FUNC_START, BYTE_W'($urandom_range(0, 255)));
            sent++;
            while (sb.frame_busy() && sent < budget) begin
                if ($urandom_range(0, 39) == 0)
                    send_req(FUNC_START, BYTE_W'($urandom_range(0, 255)));
                else
                    send_req(FUNC_TICK, BYTE_W'($urandom_range(0, 255)));
                sent++;
            end
            repeat ($urandom_range(0, 2)) send_req(FUNC_TICK, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_HEAD_TICKS;
        i_cfg_wdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle tick, then a restart during the head phase at reset settings
        send_req(FUNC_TICK, 8'hFF);
        send_req(FUNC_START, 8'hA5);
        send_req(FUNC_TICK, 8'h00);
        send_req(FUNC_TICK, 8'h00);
        send_req(FUNC_START, 8'h5A);
        send_req(FUNC_TICK, 8'h00);
        wait_results_drained();

        // zero tick counts: one full frame, then a tick while idle
        write_tick_regs(8'd0, 8'd0);
        send_req(FUNC_START, 8'hF0);
        while (sb.frame_busy()) send_req(FUNC_TICK, 8'h00);
        send_req(FUNC_TICK, 8'h00);
        wait_results_drained();

        send_frames(80);
        wait_results_drained();
        write_tick_regs(8'd255, 8'd1);
        send_frames(290);
        wait_results_drained();
        write_tick_regs(8'd0, 8'd255);
        send_frames(100);
        repeat (4) begin
            wait_results_drained();
            write_tick_regs(TICK_W'($urandom_range(0, 12)), TICK_W'($urandom_range(0, 6)));
            send_frames(30);
        end

        wait_results_drained();
        idle_en = 1'b0;
        write_tick_regs(TICK_W'($urandom_range(0, 12)), TICK_W'($urandom_range(0, 6)));
        send_frames(80);
        wait_results_drained();

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("pulse_width_byte_sender_core_tb passed");
        else
            $display("pulse_width_byte_sender_core_tb failed");
        $finish;
    end

endmodule
